// ----- sv/tmtc_pkg.sv -----
// shared types and constants of the text mode teletype console
// used by the controller, the datapath and the top level
package tmtc_pkg;

    localparam int IDX_W = 17;

    localparam logic [2:0] ACT_TTY         = 3'd0;
    localparam logic [2:0] ACT_WRITE_CA    = 3'd1;
    localparam logic [2:0] ACT_WRITE_C     = 3'd2;
    localparam logic [2:0] ACT_SET_CURSOR  = 3'd3;
    localparam logic [2:0] ACT_READ        = 3'd4;
    localparam logic [2:0] ACT_SCROLL_UP   = 3'd5;
    localparam logic [2:0] ACT_SCROLL_DOWN = 3'd6;

    localparam logic [1:0] CFG_COLUMNS  = 2'd0;
    localparam logic [1:0] CFG_LAST_ROW = 2'd1;
    localparam logic [1:0] CFG_ACTIVE   = 2'd2;

    // cell walk launch codes
    localparam logic [1:0] L_REP  = 2'd0;
    localparam logic [1:0] L_CHAR = 2'd1;
    localparam logic [1:0] L_COPY = 2'd2;
    localparam logic [1:0] L_TAIL = 2'd3;

    localparam logic [7:0]  CH_CR      = 8'h0d;
    localparam logic [7:0]  CH_LF      = 8'h0a;
    localparam logic [7:0]  CH_BS      = 8'h08;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  ATTR_DEF   = 8'h07;
    localparam logic [15:0] BLANK_CELL = 16'h0720;

    typedef struct packed {
        logic       latch;
        logic       decode;
        logic       tty;
        logic       set_cur;
        logic       scr_arm;
        logic       rd_base;
        logic       capture;
        logic       launch_en;
        logic [1:0] launch;
        logic       eng_rd;
        logic       eng_wr;
        logic       tty_put;
        logic       sc_dec;
        logic       clr_step;
        logic       out_load;
    } tmtc_cmd_t;

    typedef struct packed {
        logic [2:0] act;
        logic       pg_ok;
        logic       full_ok;
        logic       ap_ok;
        logic       base_in;
        logic       rep_nz;
        logic       printable;
        logic       sc_zero;
        logic       cnt_zero;
        logic       cnt_one;
        logic       two_phase;
        logic       clr_last;
        logic       out_free;
    } tmtc_status_t;

endpackage

// ----- sv/text_mode_teletype_console.sv -----
// top level of the text mode teletype console
// depends on tmtc_pkg, tmtc_ctrl and tmtc_datapath
//
// Text console with PAGE_COUNT pages of PAGE_CELLS cells held in one single-port
// cell memory. After reset a clearing pass fills every cell with 0x0720 while
// in_stall stays high; configuration writes are taken during it. One
// transaction is worked at a time. Printed characters are not stored when the
// cursor lies beyond the page. Char+attr writes write each cell once, and
// char-only writes read then write each cell on the one memory port. A page
// scroll moves min(screen_columns*last_row, PAGE_CELLS) cells, each read then
// written, then blanks the freed row; a teletype step may scroll more than once.
// A finished result waits in the output register while the next item is taken.
module text_mode_teletype_console #(
    parameter int PAGE_COUNT = 8,
    parameter int PAGE_CELLS = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [2:0]  page,
    input  logic [7:0]  char_code,
    input  logic [7:0]  attribute,
    input  logic [15:0] repeat_count,
    input  logic [7:0]  cursor_row,
    input  logic [7:0]  cursor_col,
    input  logic [7:0]  window_left_col,
    input  logic [7:0]  window_right_col,
    input  logic [7:0]  line_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  cell_char,
    output logic [7:0]  cell_attr,
    output logic [7:0]  row_after,
    output logic [7:0]  col_after
);
    import tmtc_pkg::*;

    tmtc_cmd_t    cmd;
    tmtc_status_t st;

    tmtc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .st       (st)
    );

    tmtc_datapath #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_CELLS (PAGE_CELLS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .action           (action),
        .page             (page),
        .char_code        (char_code),
        .attribute        (attribute),
        .repeat_count     (repeat_count),
        .cursor_row       (cursor_row),
        .cursor_col       (cursor_col),
        .window_left_col  (window_left_col),
        .window_right_col (window_right_col),
        .line_count       (line_count),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .cell_char        (cell_char),
        .cell_attr        (cell_attr),
        .row_after        (row_after),
        .col_after        (col_after)
    );

endmodule

// ----- sv/tmtc_ctrl.sv -----
// controller state machine of the text mode teletype console
// depends on tmtc_pkg for the command and status structs
module tmtc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output tmtc_pkg::tmtc_cmd_t   cmd,
    input  tmtc_pkg::tmtc_status_t st
);
    import tmtc_pkg::*;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_DISP  = 4'd3;
    localparam logic [3:0] S_READ  = 4'd4;
    localparam logic [3:0] S_PUT   = 4'd5;
    localparam logic [3:0] S_SCHK  = 4'd6;
    localparam logic [3:0] S_SFILL = 4'd7;
    localparam logic [3:0] S_SNEXT = 4'd8;
    localparam logic [3:0] S_GO    = 4'd9;
    localparam logic [3:0] S_RD    = 4'd10;
    localparam logic [3:0] S_WR    = 4'd11;
    localparam logic [3:0] S_FILL  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [3:0] ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ret_reg   <= S_DONE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.decode = 1'b1;
                state_next = S_DISP;
            end
            S_DISP:
            begin
                state_next = S_DONE;
                if (st.act == ACT_SCROLL_UP || st.act == ACT_SCROLL_DOWN)
                begin
                    if (st.full_ok && st.ap_ok)
                    begin
                        cmd.scr_arm = 1'b1;
                        state_next  = S_SCHK;
                    end
                end
                else if (st.pg_ok)
                begin
                    case (st.act)
                        ACT_TTY:
                        begin
                            cmd.tty    = 1'b1;
                            state_next = (st.printable && st.base_in) ? S_PUT : S_SCHK;
                        end
                        ACT_WRITE_CA, ACT_WRITE_C:
                        begin
                            if (st.rep_nz && st.base_in)
                            begin
                                cmd.launch_en = 1'b1;
                                cmd.launch    = (st.act == ACT_WRITE_CA) ? L_REP : L_CHAR;
                                ret_next      = S_DONE;
                                state_next    = S_GO;
                            end
                        end
                        ACT_SET_CURSOR: cmd.set_cur = 1'b1;
                        ACT_READ:
                        begin
                            cmd.rd_base = 1'b1;
                            state_next  = S_READ;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = S_DONE;
            end
            S_PUT:
            begin
                cmd.tty_put = 1'b1;
                state_next  = S_SCHK;
            end
            S_SCHK:
            begin
                if (st.sc_zero)
                    state_next = S_DONE;
                else
                begin
                    cmd.launch_en = 1'b1;
                    cmd.launch    = L_COPY;
                    ret_next      = S_SFILL;
                    state_next    = S_GO;
                end
            end
            S_SFILL:
            begin
                cmd.launch_en = 1'b1;
                cmd.launch    = L_TAIL;
                ret_next      = S_SNEXT;
                state_next    = S_GO;
            end
            S_SNEXT:
            begin
                cmd.sc_dec = 1'b1;
                state_next = S_SCHK;
            end
            S_GO:
            begin
                if (st.cnt_zero)
                    state_next = ret_reg;
                else
                    state_next = st.two_phase ? S_RD : S_FILL;
            end
            S_RD:
            begin
                cmd.eng_rd = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.eng_wr = 1'b1;
                state_next = st.cnt_one ? ret_reg : S_RD;
            end
            S_FILL:
            begin
                cmd.eng_wr = 1'b1;
                if (st.cnt_one)
                    state_next = ret_reg;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- sv/tmtc_datapath.sv -----
// datapath of the text mode teletype console: registers, cursors, cell memory
// and the cell walk counters; depends on tmtc_pkg
module tmtc_datapath #(
    parameter int PAGE_COUNT = 8,
    parameter int PAGE_CELLS = 2048
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tmtc_pkg::tmtc_cmd_t    cmd,
    output tmtc_pkg::tmtc_status_t st,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic [2:0]             action,
    input  logic [2:0]             page,
    input  logic [7:0]             char_code,
    input  logic [7:0]             attribute,
    input  logic [15:0]            repeat_count,
    input  logic [7:0]             cursor_row,
    input  logic [7:0]             cursor_col,
    input  logic [7:0]             window_left_col,
    input  logic [7:0]             window_right_col,
    input  logic [7:0]             line_count,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [7:0]             cell_char,
    output logic [7:0]             cell_attr,
    output logic [7:0]             row_after,
    output logic [7:0]             col_after
);
    import tmtc_pkg::*;

    localparam int DEPTH = PAGE_COUNT * PAGE_CELLS;
    localparam int MAW   = $clog2(DEPTH);
    localparam int LW    = $clog2(PAGE_CELLS);
    localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam logic [IDX_W-1:0] PC_I = IDX_W'(PAGE_CELLS);
    localparam logic [3:0] PCNT = 4'(PAGE_COUNT);
    localparam logic [MAW-1:0] CLR_END = MAW'(DEPTH - 1);

    localparam logic [1:0] M_FILL = 2'd0;
    localparam logic [1:0] M_UP   = 2'd1;
    localparam logic [1:0] M_DOWN = 2'd2;
    localparam logic [1:0] M_CHAR = 2'd3;

    logic [15:0] mem [DEPTH];

    logic [7:0]  cols_reg, lrow_reg;
    logic [2:0]  ap_reg;
    logic [7:0]  cur_row_reg [PAGE_COUNT];
    logic [7:0]  cur_col_reg [PAGE_COUNT];
    logic [2:0]  act_reg, pg_reg, epg_reg;
    logic [7:0]  ch_reg, attr_reg, row_reg, col_reg, fill_attr_reg;
    logic [15:0] rep_reg;
    logic        full_reg, dir_reg;
    logic [IDX_W-1:0] base_reg, n_reg, p_reg, cnt_reg;
    logic [1:0]  mode_reg;
    logic [15:0] val_reg, rdata_reg;
    logic [8:0]  sc_reg;
    logic [MAW-1:0] clr_reg;
    logic [7:0]  res_char_reg, res_attr_reg;
    logic        out_valid_reg;
    logic [7:0]  cchar_reg, cattr_reg, orow_reg, ocol_reg;

    logic [PW-1:0] pg_idx;
    logic [7:0]  cur_y, cur_x;
    logic [15:0] row_prod, n_prod;
    logic        pg_ok;

    assign pg_idx   = pg_reg[PW-1:0];
    assign cur_y    = cur_row_reg[pg_idx];
    assign cur_x    = cur_col_reg[pg_idx];
    assign row_prod = 16'(cur_y) * 16'(cols_reg);
    assign n_prod   = 16'(cols_reg) * 16'(lrow_reg);
    assign pg_ok    = ({1'b0, pg_reg} < PCNT);

    function automatic logic [LW-1:0] loc(input logic [IDX_W-1:0] idx);
        logic [LW-1:0] r;
        r = (idx < PC_I) ? idx[LW-1:0] : '0;
        return r;
    endfunction

    function automatic logic [MAW-1:0] maddr(input logic [2:0] pgv, input logic [LW-1:0] l);
        logic [MAW-1:0] a;
        a = MAW'(32'(pgv) * PAGE_CELLS + 32'(l));
        return a;
    endfunction

    // teletype cursor movement and scroll count
    logic [8:0] x9, y9, sc9;
    logic [7:0] tx, ty;
    logic       wrapchk, printable;

    always_comb
    begin
        tx      = cur_x;
        ty      = cur_y;
        sc9     = '0;
        y9      = {1'b0, cur_y};
        x9      = {1'b0, cur_x};
        wrapchk = 1'b0;
        case (ch_reg)
            CH_CR: tx = '0;
            CH_LF:
            begin
                y9      = y9 + 9'd1;
                wrapchk = 1'b1;
            end
            CH_BS:
            begin
                if (cur_x != 8'd0)
                    tx = cur_x - 8'd1;
            end
            default:
            begin
                x9 = x9 + 9'd1;
                if (x9 >= {1'b0, cols_reg})
                begin
                    y9 = y9 + 9'd1;
                    x9 = x9 - {1'b0, cols_reg};
                end
                tx      = x9[7:0];
                wrapchk = 1'b1;
            end
        endcase
        if (wrapchk)
        begin
            if (y9 > {1'b0, lrow_reg})
            begin
                sc9 = y9 - {1'b0, lrow_reg};
                ty  = lrow_reg;
            end
            else
                ty = y9[7:0];
        end
    end

    assign printable = (ch_reg != CH_CR) && (ch_reg != CH_LF) && (ch_reg != CH_BS);

    // start values of a cell walk
    logic [IDX_W-1:0] w_i, pcb, pcn, rep_i, cpy_cnt, p_next, cnt_next;
    logic [1:0]  mode_next;
    logic [15:0] val_next;

    assign w_i   = IDX_W'(cols_reg);
    assign pcb   = PC_I - base_reg;
    assign pcn   = PC_I - n_reg;
    assign rep_i = IDX_W'(rep_reg);
    assign cpy_cnt = (n_reg < PC_I) ? n_reg : PC_I;

    always_comb
    begin
        p_next    = base_reg;
        cnt_next  = (rep_i < pcb) ? rep_i : pcb;
        mode_next = M_FILL;
        val_next  = {attr_reg, ch_reg};
        case (cmd.launch)
            L_REP: mode_next = M_FILL;
            L_CHAR: mode_next = M_CHAR;
            L_COPY:
            begin
                cnt_next  = cpy_cnt;
                p_next    = dir_reg ? cpy_cnt - 1'b1 : '0;
                mode_next = dir_reg ? M_DOWN : M_UP;
            end
            L_TAIL:
            begin
                val_next = {fill_attr_reg, CH_SPACE};
                if (dir_reg)
                begin
                    p_next   = '0;
                    cnt_next = (w_i < PC_I) ? w_i : PC_I;
                end
                else
                begin
                    p_next   = n_reg;
                    cnt_next = (n_reg >= PC_I) ? '0 : ((w_i < pcn) ? w_i : pcn);
                end
            end
            default: mode_next = M_FILL;
        endcase
    end

    // cell walk addressing and write data
    logic [IDX_W-1:0] src, dst;
    logic [15:0] eng_wd;

    assign src = (mode_reg == M_UP) ? p_reg + w_i : p_reg;
    assign dst = (mode_reg == M_DOWN) ? p_reg + w_i : p_reg;

    always_comb
    begin
        case (mode_reg)
            M_FILL: eng_wd = val_reg;
            M_UP:   eng_wd = (src < PC_I) ? rdata_reg : BLANK_CELL;
            M_DOWN: eng_wd = rdata_reg;
            M_CHAR: eng_wd = {rdata_reg[15:8], ch_reg};
            default: eng_wd = val_reg;
        endcase
    end

    logic           mem_we, mem_re;
    logic [MAW-1:0] waddr, raddr;
    logic [15:0]    wdata;

    always_comb
    begin
        mem_we = 1'b0;
        waddr  = clr_reg;
        wdata  = BLANK_CELL;
        if (cmd.clr_step)
            mem_we = 1'b1;
        else if (cmd.tty_put)
        begin
            mem_we = 1'b1;
            waddr  = maddr(epg_reg, loc(base_reg));
            wdata  = {ATTR_DEF, ch_reg};
        end
        else if (cmd.eng_wr && dst < PC_I)
        begin
            mem_we = 1'b1;
            waddr  = maddr(epg_reg, loc(dst));
            wdata  = eng_wd;
        end
    end

    assign mem_re = cmd.rd_base | cmd.eng_rd;
    assign raddr  = cmd.rd_base ? maddr(epg_reg, loc(base_reg)) : maddr(epg_reg, loc(src));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (mem_re)
            rdata_reg <= mem[raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg      <= 8'd80;
            lrow_reg      <= 8'd24;
            ap_reg        <= '0;
            for (int i = 0; i < PAGE_COUNT; i++)
            begin
                cur_row_reg[i] <= '0;
                cur_col_reg[i] <= '0;
            end
            clr_reg       <= '0;
            sc_reg        <= '0;
            cnt_reg       <= '0;
            mode_reg      <= M_FILL;
            dir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COLUMNS:  cols_reg <= cfg_data;
                    CFG_LAST_ROW: lrow_reg <= cfg_data;
                    CFG_ACTIVE:   ap_reg   <= cfg_data[2:0];
                    default:      ;
                endcase
            end
            if (cmd.clr_step)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.tty)
            begin
                cur_row_reg[pg_idx] <= ty;
                cur_col_reg[pg_idx] <= tx;
                sc_reg  <= sc9;
                dir_reg <= 1'b0;
            end
            if (cmd.set_cur)
            begin
                cur_row_reg[pg_idx] <= row_reg;
                cur_col_reg[pg_idx] <= col_reg;
            end
            if (cmd.scr_arm)
            begin
                sc_reg  <= 9'd1;
                dir_reg <= (act_reg == ACT_SCROLL_DOWN);
            end
            if (cmd.sc_dec)
                sc_reg <= sc_reg - 9'd1;
            if (cmd.launch_en)
            begin
                cnt_reg  <= cnt_next;
                mode_reg <= mode_next;
            end
            else if (cmd.eng_wr)
                cnt_reg <= cnt_reg - 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg      <= action;
            pg_reg       <= page;
            ch_reg       <= char_code;
            attr_reg     <= attribute;
            rep_reg      <= repeat_count;
            row_reg      <= cursor_row;
            col_reg      <= cursor_col;
            full_reg     <= (window_left_col == 8'd0) && (window_right_col == cols_reg)
                            && (line_count == 8'd1);
            res_char_reg <= '0;
            res_attr_reg <= '0;
        end
        if (cmd.decode)
        begin
            base_reg <= IDX_W'(cur_x) + IDX_W'(row_prod);
            n_reg    <= IDX_W'(n_prod);
            epg_reg  <= pg_reg;
        end
        if (cmd.tty)
            fill_attr_reg <= ATTR_DEF;
        if (cmd.scr_arm)
        begin
            epg_reg       <= ap_reg;
            fill_attr_reg <= attr_reg;
        end
        if (cmd.launch_en)
        begin
            p_reg   <= p_next;
            val_reg <= val_next;
        end
        else if (cmd.eng_wr)
            p_reg <= (mode_reg == M_DOWN) ? p_reg - 1'b1 : p_reg + 1'b1;
        if (cmd.capture)
        begin
            res_char_reg <= (base_reg < PC_I) ? rdata_reg[7:0]  : BLANK_CELL[7:0];
            res_attr_reg <= (base_reg < PC_I) ? rdata_reg[15:8] : BLANK_CELL[15:8];
        end
        if (cmd.out_load)
        begin
            cchar_reg <= res_char_reg;
            cattr_reg <= res_attr_reg;
            orow_reg  <= pg_ok ? cur_y : 8'd0;
            ocol_reg  <= pg_ok ? cur_x : 8'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_char = cchar_reg;
    assign cell_attr = cattr_reg;
    assign row_after = orow_reg;
    assign col_after = ocol_reg;

    assign st.act       = act_reg;
    assign st.pg_ok     = pg_ok;
    assign st.full_ok   = full_reg;
    assign st.ap_ok     = ({1'b0, ap_reg} < PCNT);
    assign st.base_in   = (base_reg < PC_I);
    assign st.rep_nz    = (rep_reg != 16'd0);
    assign st.printable = printable;
    assign st.sc_zero   = (sc_reg == 9'd0);
    assign st.cnt_zero  = (cnt_reg == '0);
    assign st.cnt_one   = (cnt_reg == IDX_W'(1));
    assign st.two_phase = (mode_reg != M_FILL);
    assign st.clr_last  = (clr_reg == CLR_END);
    assign st.out_free  = !out_valid_reg || !out_stall;

endmodule

// ----- sv/tmtc_checker.sv -----
// port level checks of the text mode teletype console
// bound to text_mode_teletype_console, sees its ports only
module tmtc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] cell_char,
    input logic [7:0] cell_attr,
    input logic [7:0] row_after,
    input logic [7:0] col_after
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(cell_char) && $stable(cell_attr)
                                   && $stable(row_after) && $stable(col_after))
        else $error("result changed while stalled");

    // one transaction in work at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while busy");

    // in_stall is high while reset is held, so nothing is taken
    a_reset_stall: assert property (@(posedge clk) !rst_n |-> in_stall)
        else $error("input open during reset");

endmodule

bind text_mode_teletype_console tmtc_checker u_tmtc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cell_char (cell_char),
    .cell_attr (cell_attr),
    .row_after (row_after),
    .col_after (col_after)
);

// ----- bench/tb_top.sv -----
// self-checking testbench of the text mode teletype console
// depends on tmtc_pkg and text_mode_teletype_console; it predicts every result itself
`timescale 1ns / 100ps

module tb_top;
    import tmtc_pkg::*;

    localparam int NPAGES = 8;
    localparam int NCELLS = 2048;
    localparam longint CYCLE_LIMIT = 40000000;
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]  act;
        logic [2:0]  pg;
        logic [7:0]  ch;
        logic [7:0]  attr;
        logic [15:0] rep;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [7:0]  left;
        logic [7:0]  right;
        logic [7:0]  lines;
    } console_cmd_t;

    typedef struct {
        logic [7:0] ch;
        logic [7:0] attr;
        logic [7:0] row;
        logic [7:0] col;
    } console_res_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [2:0]  page;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [15:0] repeat_count;
    logic [7:0]  cursor_row;
    logic [7:0]  cursor_col;
    logic [7:0]  window_left_col;
    logic [7:0]  window_right_col;
    logic [7:0]  line_count;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [7:0]  row_after;
    logic [7:0]  col_after;

    // predicted console contents and settings
    logic [15:0] screen_mem [NPAGES*NCELLS];
    logic [15:0] cursor_pos [NPAGES];
    int unsigned cols_cfg;
    int unsigned last_row_cfg;
    int unsigned active_cfg;

    console_res_t pending_results[$];
    int  error_count = 0;
    bit  calm = 1'b0;
    longint cycles = 0;

    text_mode_teletype_console uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // ---------------- predictor ----------------
    function automatic logic [15:0] cell_at(int unsigned pg, int unsigned idx);
        if (idx >= NCELLS)
            return BLANK_CELL;
        return screen_mem[pg*NCELLS + idx];
    endfunction

    function automatic void cell_store(int unsigned pg, int unsigned idx, logic [15:0] v);
        if (idx < NCELLS)
            screen_mem[pg*NCELLS + idx] = v;
    endfunction

    function automatic int unsigned cursor_cell(int unsigned pg);
        return cursor_pos[pg][7:0] + cursor_pos[pg][15:8] * cols_cfg;
    endfunction

    function automatic void page_up(int unsigned pg, logic [7:0] fill);
        int unsigned w;
        int unsigned n;
        w = cols_cfg;
        n = cols_cfg * last_row_cfg;
        for (int unsigned i = 0; i < n && i < NCELLS; i++)
            cell_store(pg, i, cell_at(pg, i + w));
        for (int unsigned i = 0; i < w; i++)
            cell_store(pg, n + i, {fill, CH_SPACE});
    endfunction

    function automatic void page_down(int unsigned pg, logic [7:0] fill);
        int unsigned w;
        int unsigned n;
        w = cols_cfg;
        n = cols_cfg * last_row_cfg;
        if (n > NCELLS)
            n = NCELLS;
        for (int unsigned i = n; i > 0; i--)
            cell_store(pg, i - 1 + w, cell_at(pg, i - 1));
        for (int unsigned i = 0; i < w; i++)
            cell_store(pg, i, {fill, CH_SPACE});
    endfunction

    function automatic void teletype_char(int unsigned pg, logic [7:0] ch);
        int unsigned y;
        int unsigned x;
        y = cursor_pos[pg][15:8];
        x = cursor_pos[pg][7:0];
        if (ch == CH_CR)
            x = 0;
        else if (ch == CH_LF)
        begin
            y++;
            while (y >= last_row_cfg + 1)
            begin
                page_up(pg, ATTR_DEF);
                y--;
            end
        end
        else if (ch == CH_BS)
        begin
            if (x > 0)
                x--;
        end
        else
        begin
            cell_store(pg, cursor_cell(pg), {ATTR_DEF, ch});
            x++;
            if (x >= cols_cfg)
            begin
                y++;
                x -= cols_cfg;
            end
            while (y >= last_row_cfg + 1)
            begin
                page_up(pg, ATTR_DEF);
                y--;
            end
        end
        cursor_pos[pg] = {y[7:0], x[7:0]};
    endfunction

    function automatic console_res_t console_step(console_cmd_t c);
        console_res_t r;
        int unsigned base;
        logic [15:0] rd;
        bit full;
        r = '{default: '0};
        full = (c.left == 0 && c.right == cols_cfg && c.lines == 1);
        case (c.act)
            ACT_TTY:
                teletype_char(c.pg, c.ch);
            ACT_WRITE_CA:
            begin
                base = cursor_cell(c.pg);
                for (int unsigned i = 0; i < c.rep && base + i < NCELLS; i++)
                    cell_store(c.pg, base + i, {c.attr, c.ch});
            end
            ACT_WRITE_C:
            begin
                base = cursor_cell(c.pg);
                for (int unsigned i = 0; i < c.rep && base + i < NCELLS; i++)
                    cell_store(c.pg, base + i,
                               (cell_at(c.pg, base + i) & 16'hff00) | {8'h00, c.ch});
            end
            ACT_SET_CURSOR:
                cursor_pos[c.pg] = {c.row, c.col};
            ACT_READ:
            begin
                rd = cell_at(c.pg, cursor_cell(c.pg));
                r.ch = rd[7:0];
                r.attr = rd[15:8];
            end
            default: ;
        endcase
        if (full && c.act == ACT_SCROLL_UP)
            page_up(active_cfg, c.attr);
        else if (full && c.act == ACT_SCROLL_DOWN)
            page_down(active_cfg, c.attr);
        r.row = cursor_pos[c.pg][15:8];
        r.col = cursor_pos[c.pg][7:0];
        return r;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        console_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report("result with nothing expected");
            else
            begin
                e = pending_results.pop_front();
                if (cell_char !== e.ch)
                    report($sformatf("cell_char %h expected %h", cell_char, e.ch));
                if (cell_attr !== e.attr)
                    report($sformatf("cell_attr %h expected %h", cell_attr, e.attr));
                if (row_after !== e.row)
                    report($sformatf("row_after %0d expected %0d", row_after, e.row));
                if (col_after !== e.col)
                    report($sformatf("col_after %0d expected %0d", col_after, e.col));
            end
        end
        out_stall <= !calm && ($urandom_range(99) < 32);
    end

    // ---------------- drivers ----------------
    task automatic send_cmd(input console_cmd_t c);
        if (!calm && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        action           <= c.act;
        page             <= c.pg;
        char_code        <= c.ch;
        attribute        <= c.attr;
        repeat_count     <= c.rep;
        cursor_row       <= c.row;
        cursor_col       <= c.col;
        window_left_col  <= c.left;
        window_right_col <= c.right;
        line_count       <= c.lines;
        in_valid         <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(console_step(c));
    endtask

    // drains the console, then writes all three registers
    task automatic set_config(input int unsigned cols, input int unsigned lr,
                              input int unsigned ap);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (10) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_COLUMNS;
        cfg_data <= cols[7:0];
        @(posedge clk);
        cfg_index <= CFG_LAST_ROW;
        cfg_data <= lr[7:0];
        @(posedge clk);
        cfg_index <= CFG_ACTIVE;
        cfg_data <= ap[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        cols_cfg = cols;
        last_row_cfg = lr;
        active_cfg = ap;
    endtask

    function automatic console_cmd_t mk(logic [2:0] act, logic [2:0] pg, logic [7:0] ch = 0,
                                        logic [7:0] attr = 0, logic [15:0] rep = 0,
                                        logic [7:0] row = 0, logic [7:0] col = 0);
        console_cmd_t c;
        c = '{act: act, pg: pg, ch: ch, attr: attr, rep: rep, row: row, col: col,
              left: 8'd0, right: cols_cfg[7:0], lines: 8'd1};
        return c;
    endfunction

    function automatic console_cmd_t rand_cmd(bit deep_rows);
        console_cmd_t c;
        int unsigned p;
        c.act = 3'($urandom_range(ACT_SCROLL_DOWN));
        c.pg = 3'($urandom_range(NPAGES - 1));
        c.ch = 8'($urandom);
        c.attr = 8'($urandom);
        c.rep = 16'($urandom_range(0, 40));
        c.row = 8'($urandom_range(0, last_row_cfg));
        c.col = 8'($urandom_range(0, cols_cfg > 0 ? cols_cfg - 1 : 0));
        c.left = 8'($urandom);
        c.right = 8'($urandom);
        c.lines = 8'($urandom);
        p = $urandom_range(99);
        // teletype dominates, with control characters mixed in
        if (p < 30)
        begin
            c.act = ACT_TTY;
            case ($urandom_range(5))
                0: c.ch = CH_CR;
                1: c.ch = CH_LF;
                2: c.ch = CH_BS;
                default: ;
            endcase
        end
        else if (p < 32)
            c.act = ACT_UNUSED;
        if ($urandom_range(99) < 3)
            c.rep = 16'($urandom);
        if ($urandom_range(99) < 10)
            c.col = 8'($urandom);
        if (deep_rows && $urandom_range(99) < 5)
            c.row = 8'($urandom);
        // half of the scrolls get a set-up window: well formed or a near miss
        if ((c.act == ACT_SCROLL_UP || c.act == ACT_SCROLL_DOWN) && $urandom_range(1))
        begin
            c.left = 8'd0;
            c.right = cols_cfg[7:0];
            c.lines = 8'd1;
            case ($urandom_range(5))
                0: c.left = 8'd1;
                1: c.right = 8'(cols_cfg + 1);
                2: c.lines = $urandom_range(1) ? 8'd0 : 8'd2;
                default: ;
            endcase
        end
        return c;
    endfunction

    task automatic run_random(input int n, input bit deep_rows);
        for (int i = 0; i < n; i++)
            send_cmd(rand_cmd(deep_rows));
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        console_cmd_t c;
        send_cmd(mk(ACT_READ, 0));
        send_cmd(mk(ACT_WRITE_CA, 1, 8'hff, 8'hff, 16'd3));
        send_cmd(mk(ACT_READ, 1));
        send_cmd(mk(ACT_WRITE_C, 1, 8'h00, 8'h00, 16'd5));
        send_cmd(mk(ACT_READ, 1));
        send_cmd(mk(ACT_WRITE_CA, 2, 8'h41, 8'h00, 16'd0));
        send_cmd(mk(ACT_WRITE_CA, 3, 8'h5a, 8'h1e, 16'hffff, 8'd20, 8'd10));
        send_cmd(mk(ACT_SET_CURSOR, 3, 0, 0, 0, 8'd24, 8'd79));
        send_cmd(mk(ACT_TTY, 3, 8'h42));
        send_cmd(mk(ACT_TTY, 3, CH_BS));
        send_cmd(mk(ACT_TTY, 3, CH_CR));
        send_cmd(mk(ACT_TTY, 3, CH_BS));
        send_cmd(mk(ACT_TTY, 3, CH_LF));
        send_cmd(mk(ACT_READ, 3));
        // cursor beyond the page storage: write dropped, read blank
        send_cmd(mk(ACT_SET_CURSOR, 4, 0, 0, 0, 8'hff, 8'hff));
        send_cmd(mk(ACT_WRITE_CA, 4, 8'h33, 8'h44, 16'd2));
        send_cmd(mk(ACT_READ, 4));
        // cursor below the screen scrolls once per excess row
        send_cmd(mk(ACT_SET_CURSOR, 5, 0, 0, 0, 8'd26, 8'd3));
        send_cmd(mk(ACT_TTY, 5, 8'h61));
        send_cmd(mk(ACT_SCROLL_UP, 6, 0, 8'h1f));
        send_cmd(mk(ACT_SCROLL_DOWN, 6, 0, 8'he0));
        c = mk(ACT_SCROLL_UP, 0, 0, 8'h55);
        c.left = 8'd1;
        send_cmd(c);
        c = mk(ACT_SCROLL_DOWN, 0, 0, 8'h55);
        c.lines = 8'd2;
        send_cmd(c);
        send_cmd(mk(ACT_UNUSED, 7, 8'hff, 8'hff, 16'hffff, 8'hff, 8'hff));
        send_cmd(mk(ACT_READ, 7));
    endtask

    task automatic test_zero_columns();
        set_config(0, 3, 1);
        for (int i = 0; i < 6; i++)
            send_cmd(mk(ACT_TTY, 1, 8'(8'h30 + i)));
        run_random(60, 1'b1);
    endtask

    task automatic test_wide_screen();
        set_config(255, 254, 7);
        send_cmd(mk(ACT_SET_CURSOR, 7, 0, 0, 0, 8'd254, 8'd254));
        send_cmd(mk(ACT_TTY, 7, 8'h7e));
        send_cmd(mk(ACT_READ, 7));
        run_random(40, 1'b0);
    endtask

    task automatic test_small_screens();
        set_config(20, 5, 2);
        run_random(350, 1'b1);
        set_config(1, 0, 5);
        run_random(250, 1'b1);
        set_config(7, 12, 3);
        calm = 1'b1;
        run_random(300, 1'b1);
        calm = 1'b0;
        set_config(40, 10, 6);
        run_random(350, 1'b1);
    endtask

    task automatic test_default_screen();
        set_config(80, 24, 0);
        run_random(150, 1'b0);
    endtask

    task automatic test_tiny_rows();
        set_config(3, 1, 4);
        run_random(200, 1'b1);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_COLUMNS;
        cfg_data <= '0;
        in_valid <= 1'b0;
        action <= ACT_TTY;
        page <= '0;
        char_code <= '0;
        attribute <= '0;
        repeat_count <= '0;
        cursor_row <= '0;
        cursor_col <= '0;
        window_left_col <= '0;
        window_right_col <= '0;
        line_count <= '0;
        out_stall <= 1'b0;
        foreach (screen_mem[i])
            screen_mem[i] = BLANK_CELL;
        foreach (cursor_pos[i])
            cursor_pos[i] = '0;
        cols_cfg = 80;
        last_row_cfg = 24;
        active_cfg = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_zero_columns();
        test_wide_screen();
        test_small_screens();
        test_tiny_rows();
        test_default_screen();

        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- text_mode_teletype_console.f -----
sv/tmtc_pkg.sv
sv/tmtc_ctrl.sv
sv/tmtc_datapath.sv
sv/text_mode_teletype_console.sv
sv/tmtc_checker.sv
bench/tb_top.sv
